/* rtl/core/ffsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg: shared codes for the first-fit segment allocator
// Operation codes and result status codes used by the unit and its checker.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  // operation codes
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;
  localparam logic [1:0] FUNC_INIT  = 2'd3;

  // result status codes
  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_NO_FIT   = 3'd1;
  localparam logic [2:0] STATUS_FULL     = 3'd2;
  localparam logic [2:0] STATUS_BAD_HDL  = 3'd3;
  localparam logic [2:0] STATUS_ZERO_REQ = 3'd4;

endpackage

/* rtl/core/ffsa_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ffsa_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/first_fit_segment_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit: first-fit allocator with coalescing
// Segment table (start, length, used) held in one RAM in offset order.
// Allocate, free and query walk the table entry by entry.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in_       input      start & !busy          func, req_units, handle
//  out_      output     out_valid strobe       status, handle_out, seg_units, ...
//  cfg_      input      cfg_valid & cfg_ready  pool_units
//
// Initialize and immediate rejects answer in the cycle after start. Allocate
// and free take the search, a shift of the entries above the touched one
// (one per cycle, through the single RAM read port; skipped when an allocate
// fits exactly) and a rescan of the table for the largest free segment.
// Synchronous active-low reset empties the table; the RAM needs no
// clearing. The result is a one-cycle strobe and cannot be stalled.
module first_fit_segment_allocator_unit #(
  parameter int MAX_SEGMENTS = 32,
  parameter int UNIT_BITS    = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_func,
  input  logic [UNIT_BITS-1:0]                 in_req_units,
  input  logic [UNIT_BITS-1:0]                 in_handle,
  // result
  output logic                                 out_valid,
  output logic [2:0]                           out_status,
  output logic [UNIT_BITS-1:0]                 out_handle_out,
  output logic [UNIT_BITS-1:0]                 out_seg_units,
  output logic                                 out_seg_used,
  output logic [UNIT_BITS-1:0]                 out_total_allocated,
  output logic [UNIT_BITS-1:0]                 out_total_free,
  output logic [$clog2(MAX_SEGMENTS+1)-1:0]    out_segment_count,
  output logic [UNIT_BITS-1:0]                 out_largest_free,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [UNIT_BITS-1:0]                 cfg_pool_units
);
  import ffsa_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int UB = UNIT_BITS;
  localparam int EW = 1 + 2 * UB;
  localparam logic [CW-1:0] CNT_ONE = CW'(1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_NB0  = 3'd2;
  localparam logic [2:0] S_NB1  = 3'd3;
  localparam logic [2:0] S_NB2  = 3'd4;
  localparam logic [2:0] S_SHF  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_SCAN = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    func_r, func_nxt;
  logic [UB-1:0] req_r, req_nxt;
  logic [UB-1:0] hdl_r, hdl_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          chk_r, chk_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [EW-1:0] ent_r, ent_nxt;
  logic [EW-1:0] nbr_r, nbr_nxt;
  logic [IW-1:0] sh_src_r, sh_src_nxt;
  logic [CW-1:0] sh_left_r, sh_left_nxt;
  logic          sh_up_r, sh_up_nxt;
  logic          sh_vld_r, sh_vld_nxt;
  logic [IW-1:0] sh_dst_r, sh_dst_nxt;
  logic [1:0]    sh_d_r, sh_d_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [UB-1:0] used_tot_r, used_tot_nxt;
  logic [UB-1:0] pool_r, pool_nxt;
  logic [UB-1:0] large_r, large_nxt;
  logic [UB-1:0] lg_r, lg_nxt;
  logic [UB-1:0] pool_cfg_r;
  logic [2:0]    res_status_r, res_status_nxt;
  logic [UB-1:0] res_hout_r, res_hout_nxt;
  logic [UB-1:0] res_units_r, res_units_nxt;
  logic          res_used_r, res_used_nxt;
  logic          out_valid_r, out_valid_nxt;

  // RAM ports
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [IW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  // fields of entries
  logic          r_used, e_used, n_used;
  logic [UB-1:0] r_start, e_start, n_start;
  logic [UB-1:0] r_len, e_len, n_len;
  logic          issue, hit, last, mn, mp;
  logic [CW-1:0] s0;
  logic [UB-1:0] merged;

  assign {r_used, r_start, r_len} = rd_data;
  assign {e_used, e_start, e_len} = ent_r;
  assign {n_used, n_start, n_len} = nbr_r;

  ffsa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    req_nxt        = req_r;
    hdl_nxt        = hdl_r;
    k_nxt          = k_r;
    chk_nxt        = chk_r;
    chk_idx_nxt    = chk_idx_r;
    idx_nxt        = idx_r;
    ent_nxt        = ent_r;
    nbr_nxt        = nbr_r;
    sh_src_nxt     = sh_src_r;
    sh_left_nxt    = sh_left_r;
    sh_up_nxt      = sh_up_r;
    sh_vld_nxt     = sh_vld_r;
    sh_dst_nxt     = sh_dst_r;
    sh_d_nxt       = sh_d_r;
    count_nxt      = count_r;
    used_tot_nxt   = used_tot_r;
    pool_nxt       = pool_r;
    large_nxt      = large_r;
    lg_nxt         = lg_r;
    res_status_nxt = res_status_r;
    res_hout_nxt   = res_hout_r;
    res_units_nxt  = res_units_r;
    res_used_nxt   = res_used_r;
    out_valid_nxt  = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_addr        = k_r[IW-1:0];
    issue          = 1'b0;
    hit            = 1'b0;
    last           = (CW'(chk_idx_r) == count_r - CNT_ONE);
    mn             = 1'b0;
    mp             = 1'b0;
    s0             = '0;
    merged         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt       = in_func;
          req_nxt        = in_req_units;
          hdl_nxt        = in_handle;
          res_status_nxt = STATUS_OK;
          res_hout_nxt   = in_handle;
          res_units_nxt  = '0;
          res_used_nxt   = 1'b0;
          if (in_func == FUNC_INIT) begin
            wr_en         = 1'b1;
            wr_data       = {1'b0, {UB{1'b0}}, pool_cfg_r};
            count_nxt     = CNT_ONE;
            used_tot_nxt  = '0;
            pool_nxt      = pool_cfg_r;
            large_nxt     = pool_cfg_r;
            out_valid_nxt = 1'b1;
          end else if (in_func == FUNC_ALLOC && in_req_units == '0) begin
            res_status_nxt = STATUS_ZERO_REQ;
            out_valid_nxt  = 1'b1;
          end else if (count_r == '0) begin
            res_status_nxt = (in_func == FUNC_ALLOC) ? STATUS_NO_FIT : STATUS_BAD_HDL;
            out_valid_nxt  = 1'b1;
          end else begin
            state_nxt = S_SRCH;
            k_nxt     = '0;
            chk_nxt   = 1'b0;
          end
        end
      end

      // walk entries, one read per cycle, compare the previous beat
      S_SRCH: begin
        issue       = (k_r < count_r);
        k_nxt       = issue ? k_r + CNT_ONE : k_r;
        chk_nxt     = issue;
        chk_idx_nxt = k_r[IW-1:0];
        if (chk_r) begin
          hit = (func_r == FUNC_ALLOC) ? (!r_used && r_len >= req_r) : (r_start == hdl_r);
          if (hit) begin
            idx_nxt = chk_idx_r;
            ent_nxt = rd_data;
            priority if (func_r == FUNC_QUERY) begin
              res_units_nxt = r_len;
              res_used_nxt  = r_used;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else if (func_r == FUNC_FREE) begin
              if (!r_used) begin
                res_status_nxt = STATUS_BAD_HDL;
                out_valid_nxt  = 1'b1;
                state_nxt      = S_IDLE;
              end else begin
                res_units_nxt = r_len;
                used_tot_nxt  = used_tot_r - r_len;
                state_nxt     = S_NB0;
              end
            end else if (r_len > req_r && count_r == CNT_MAX) begin
              res_status_nxt = STATUS_FULL;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              wr_en         = 1'b1;
              wr_addr       = chk_idx_r;
              wr_data       = {1'b1, r_start, req_r};
              res_hout_nxt  = r_start;
              res_units_nxt = req_r;
              res_used_nxt  = 1'b1;
              used_tot_nxt  = used_tot_r + req_r;
              if (r_len > req_r) begin
                sh_src_nxt  = IW'(count_r - CNT_ONE);
                sh_left_nxt = count_r - CNT_ONE - CW'(chk_idx_r);
                sh_up_nxt   = 1'b1;
                sh_vld_nxt  = 1'b0;
                state_nxt   = S_SHF;
              end else begin
                k_nxt     = '0;
                chk_nxt   = 1'b0;
                lg_nxt    = '0;
                state_nxt = S_SCAN;
              end
            end
          end else if (last) begin
            res_status_nxt = (func_r == FUNC_ALLOC) ? STATUS_NO_FIT : STATUS_BAD_HDL;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end

      // fetch the neighbors of the freed entry
      S_NB0: begin
        rd_addr   = idx_r + IW'(1);
        state_nxt = S_NB1;
      end

      S_NB1: begin
        nbr_nxt   = rd_data;
        rd_addr   = idx_r - IW'(1);
        state_nxt = S_NB2;
      end

      // merge, write the survivor, set up the down shift
      S_NB2: begin
        mn     = (CW'(idx_r) + CNT_ONE < count_r) && !n_used;
        mp     = (idx_r != '0) && !r_used;
        merged = e_len + (mn ? n_len : '0) + (mp ? r_len : '0);
        wr_en  = 1'b1;
        if (mp) begin
          wr_addr = idx_r - IW'(1);
          wr_data = {1'b0, r_start, merged};
        end else begin
          wr_addr = idx_r;
          wr_data = {1'b0, e_start, merged};
        end
        s0          = CW'(idx_r) + CNT_ONE + CW'(mn);
        sh_src_nxt  = s0[IW-1:0];
        sh_left_nxt = count_r - s0;
        sh_d_nxt    = 2'(mn) + 2'(mp);
        count_nxt   = count_r - CW'(mn) - CW'(mp);
        sh_up_nxt   = 1'b0;
        sh_vld_nxt  = 1'b0;
        state_nxt   = S_SHF;
      end

      // move entries one slot per cycle: read src, write next beat
      S_SHF: begin
        issue      = (sh_left_r != '0);
        rd_addr    = sh_src_r;
        sh_vld_nxt = issue;
        if (issue) begin
          sh_src_nxt  = sh_up_r ? sh_src_r - IW'(1) : sh_src_r + IW'(1);
          sh_left_nxt = sh_left_r - CNT_ONE;
          sh_dst_nxt  = sh_up_r ? sh_src_r + IW'(1) : sh_src_r - IW'(sh_d_r);
        end
        if (sh_vld_r) begin
          wr_en   = 1'b1;
          wr_addr = sh_dst_r;
          wr_data = rd_data;
        end
        if (!issue && !sh_vld_r) begin
          if (sh_up_r) begin
            state_nxt = S_FIN;
          end else begin
            k_nxt     = '0;
            chk_nxt   = 1'b0;
            lg_nxt    = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      // write the split-off remainder
      S_FIN: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r + IW'(1);
        wr_data   = {1'b0, e_start + req_r, e_len - req_r};
        count_nxt = count_r + CNT_ONE;
        k_nxt     = '0;
        chk_nxt   = 1'b0;
        lg_nxt    = '0;
        state_nxt = S_SCAN;
      end

      // rescan for the largest free segment
      S_SCAN: begin
        issue       = (k_r < count_r);
        k_nxt       = issue ? k_r + CNT_ONE : k_r;
        chk_nxt     = issue;
        chk_idx_nxt = k_r[IW-1:0];
        if (chk_r) begin
          if (!r_used && r_len > lg_r) begin
            lg_nxt = r_len;
          end
          if (last) begin
            large_nxt     = lg_nxt;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_r       <= 1'b0;
      sh_vld_r    <= 1'b0;
      count_r     <= '0;
      used_tot_r  <= '0;
      pool_r      <= '0;
      large_r     <= '0;
      pool_cfg_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_r       <= chk_nxt;
      sh_vld_r    <= sh_vld_nxt;
      count_r     <= count_nxt;
      used_tot_r  <= used_tot_nxt;
      pool_r      <= pool_nxt;
      large_r     <= large_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        pool_cfg_r <= cfg_pool_units;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    req_r        <= req_nxt;
    hdl_r        <= hdl_nxt;
    k_r          <= k_nxt;
    chk_idx_r    <= chk_idx_nxt;
    idx_r        <= idx_nxt;
    ent_r        <= ent_nxt;
    nbr_r        <= nbr_nxt;
    sh_src_r     <= sh_src_nxt;
    sh_left_r    <= sh_left_nxt;
    sh_up_r      <= sh_up_nxt;
    sh_dst_r     <= sh_dst_nxt;
    sh_d_r       <= sh_d_nxt;
    lg_r         <= lg_nxt;
    res_status_r <= res_status_nxt;
    res_hout_r   <= res_hout_nxt;
    res_units_r  <= res_units_nxt;
    res_used_r   <= res_used_nxt;
  end

  // ports
  assign busy                = (state_r != S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_status          = res_status_r;
  assign out_handle_out      = res_hout_r;
  assign out_seg_units       = res_units_r;
  assign out_seg_used        = res_used_r;
  assign out_total_allocated = used_tot_r;
  assign out_total_free      = pool_r - used_tot_r;
  assign out_segment_count   = count_r;
  assign out_largest_free    = large_r;

endmodule

/* rtl/core/ffsa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_checker: port-level checks for the segment allocator
// Watches the command and result ports; bound to the top level.
// ----------------------------------------------------------------------------
module ffsa_checker #(
  parameter int MAX_SEGMENTS = 32,
  parameter int UNIT_BITS    = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [1:0]                        in_func,
  input logic [UNIT_BITS-1:0]              in_req_units,
  input logic                              out_valid,
  input logic [2:0]                        out_status,
  input logic [UNIT_BITS-1:0]              out_seg_units,
  input logic [UNIT_BITS-1:0]              out_total_free,
  input logic [$clog2(MAX_SEGMENTS+1)-1:0] out_segment_count,
  input logic [UNIT_BITS-1:0]              out_largest_free
);
  import ffsa_pkg::*;

  // initialize answers next cycle with a single segment
  a_init: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_INIT |=>
      out_valid && out_status == STATUS_OK && out_segment_count == 1)
    else $error("initialize result wrong");

  // zero request rejected at once
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_ALLOC && in_req_units == '0 |=>
      out_valid && out_status == STATUS_ZERO_REQ)
    else $error("zero request not rejected");

  // failures report no length
  a_fail_units: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> out_seg_units == '0)
    else $error("failed beat carries a length");

  // largest free segment never exceeds the free total
  a_largest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_largest_free <= out_total_free)
    else $error("largest free above free total");

  // a result only appears once the unit is idle
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

endmodule

bind first_fit_segment_allocator_unit ffsa_checker #(
  .MAX_SEGMENTS (MAX_SEGMENTS),
  .UNIT_BITS    (UNIT_BITS)
) u_ffsa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_func           (in_func),
  .in_req_units      (in_req_units),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_seg_units     (out_seg_units),
  .out_total_free    (out_total_free),
  .out_segment_count (out_segment_count),
  .out_largest_free  (out_largest_free)
);
